// ----- design/deq_pkg.sv -----
package deq_pkg;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_BACK  = 3'd5,
        CMD_CLEAR      = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    localparam int COMMAND_BITS = 3;
    localparam int DATA_BITS    = 64;
    localparam int COUNT_BITS   = 9;

    // controller -> datapath
    typedef struct packed {
        logic take;
        logic load_mem;
    } deq_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic needs_read;
    } deq_sts_t;

endpackage

// ----- design/deq_ctrl.sv -----
module deq_ctrl
    import deq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  deq_sts_t sts,
    output deq_ctl_t ctl
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   take;

    assign in_ready     = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign take         = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign ctl.take     = take;
    assign ctl.load_mem = (state_reg == S_READ);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (sts.needs_read)
                    begin
                        state_next     = S_READ;
                        out_valid_next = 1'b0;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
                else if (out_valid_reg && out_ready)
                begin
                    out_valid_next = 1'b0;
                end
            end
            S_READ:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
            end
            default:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- design/deq_dp.sv -----
module deq_dp
    import deq_pkg::*;
#(
    parameter int DEPTH     = 256,
    parameter int WORD_BITS = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [COMMAND_BITS-1:0] command,
    input  logic [DATA_BITS-1:0]    data_in,
    output logic [1:0]              status,
    output logic [DATA_BITS-1:0]    data_out,
    output logic [COUNT_BITS-1:0]   count_after,
    input  deq_ctl_t                ctl,
    output deq_sts_t                sts
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SW    = CNT_W + 1;

    logic [WORD_BITS-1:0] store_reg [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [WORD_BITS-1:0] data_reg;
    logic [AW-1:0]        front_reg, front_next;
    logic [CNT_W-1:0]     occ_reg, occ_next;
    logic [1:0]           status_reg;
    logic [CNT_W-1:0]     cnt_reg;

    logic          full, empty;
    logic [AW-1:0] front_dec, front_inc, push_pos, back_pos;
    logic [SW-1:0] push_sum, back_sum;
    logic          wr_en, rd_en;
    logic [AW-1:0] waddr, raddr;
    status_t       st;

    assign full      = (occ_reg == CNT_W'(DEPTH));
    assign empty     = (occ_reg == '0);
    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);
    assign front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + AW'(1);
    assign push_sum  = SW'(front_reg) + SW'(occ_reg);
    assign back_sum  = push_sum - SW'(1);
    assign push_pos  = (push_sum >= SW'(DEPTH)) ? AW'(push_sum - SW'(DEPTH)) : AW'(push_sum);
    assign back_pos  = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);

    always_comb
    begin
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        waddr      = front_reg;
        raddr      = front_reg;
        st         = ST_OK;
        front_next = front_reg;
        occ_next   = occ_reg;
        case (command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    wr_en    = 1'b1;
                    occ_next = occ_reg + CNT_W'(1);
                    if (command == CMD_PUSH_FRONT)
                    begin
                        waddr      = front_dec;
                        front_next = front_dec;
                    end
                    else
                    begin
                        waddr = push_pos;
                    end
                end
            end
            CMD_POP_FRONT, CMD_PEEK_FRONT:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    rd_en = 1'b1;
                    raddr = front_reg;
                    if (command == CMD_POP_FRONT)
                    begin
                        front_next = front_inc;
                        occ_next   = occ_reg - CNT_W'(1);
                    end
                end
            end
            CMD_POP_BACK, CMD_PEEK_BACK:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    rd_en = 1'b1;
                    raddr = back_pos;
                    if (command == CMD_POP_BACK)
                    begin
                        occ_next = occ_reg - CNT_W'(1);
                    end
                end
            end
            CMD_CLEAR:
            begin
                front_next = '0;
                occ_next   = '0;
            end
            default:
            begin
            end
        endcase
    end

    assign sts.needs_read = rd_en;

    always_ff @(posedge clk)
    begin
        if (ctl.take && wr_en)
        begin
            store_reg[waddr] <= data_in[WORD_BITS-1:0];
        end
        if (ctl.take && rd_en)
        begin
            rd_data_reg <= store_reg[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            occ_reg   <= '0;
        end
        else if (ctl.take)
        begin
            front_reg <= front_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            status_reg <= st;
            cnt_reg    <= occ_next;
            data_reg   <= '0;
        end
        else if (ctl.load_mem)
        begin
            data_reg <= rd_data_reg;
        end
    end

    assign status      = status_reg;
    assign data_out    = DATA_BITS'(data_reg);
    assign count_after = COUNT_BITS'(cnt_reg);

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        front_reg < AW'(DEPTH) || DEPTH == (1 << AW))
        else $error("front index out of range");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.take && command == CMD_CLEAR |=> occ_reg == '0 && front_reg == '0)
        else $error("clear left words behind");

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.take && full |-> !wr_en)
        else $error("write into full store");

endmodule

// ----- design/double_ended_queue.sv -----
// Double-ended queue of words in a circular store.
// Input channel (in_valid/in_ready) carries command and data_in: push front,
// push back, pop front, pop back, peek front, peek back, clear.
// Output channel (out_valid/out_ready) returns one item per command:
// status (ok, empty, full), data_out and count_after.
// Push, clear and refused commands: result valid in the cycle after accept,
// one item per cycle sustained while the receiver takes each result.
// Pop and peek on a non-empty queue: read via the store's registered port,
// then loaded in S_READ; no new command is accepted until S_READ ends.
// The result sits in an output register; a new item is taken in the same
// cycle that the waiting result is taken.
// A stalled receiver holds the result and in_ready stays low until it is taken.
// Reset empties the queue and sets the front index to zero; store contents
// are not cleared.
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH     = 256,
    parameter int WORD_BITS = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [COMMAND_BITS-1:0] command,
    input  logic [DATA_BITS-1:0]    data_in,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              status,
    output logic [DATA_BITS-1:0]    data_out,
    output logic [COUNT_BITS-1:0]   count_after
);

    deq_ctl_t ctl;
    deq_sts_t sts;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    deq_dp #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .command     (command),
        .data_in     (data_in),
        .status      (status),
        .data_out    (data_out),
        .count_after (count_after),
        .ctl         (ctl),
        .sts         (sts)
    );

endmodule
